/* hdl/mpwm_pkg.sv */
// Package for the multichannel PWM scheduler: opcodes, sizes, controller commands.
// Used by the controller, the datapath and the top level. No dependencies.
package mpwm_pkg;

  localparam int unsigned Channels = 8;
  localparam int unsigned ChW      = $clog2(Channels);
  localparam int unsigned CntW     = $clog2(Channels + 1);
  localparam logic [31:0] NearestCap = 32'h7fff_ffff;

  typedef enum logic [1:0] {
    OP_SERVICE = 2'd0,
    OP_ENABLE  = 2'd1,
    OP_DISABLE = 2'd2,
    OP_ADJUST  = 2'd3
  } opcode_e;

  typedef enum logic [0:0] {
    REG_TICKS_PER_US = 1'b0,
    REG_MIN_GAP      = 1'b1
  } reg_idx_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic            load;       // capture the input item
    logic            do_enable;  // allocate + resync
    logic            do_disable;
    logic            do_adjust;
    logic            svc_start;  // reset nearest accumulator
    logic            svc_step;   // process channel svc_ch
    logic [ChW-1:0]  svc_ch;
    logic            svc_done;   // write compare register
    logic            set_result; // capture the result
  } mpwm_cmd_t;

  typedef struct packed {
    logic           any_enabled;
    logic [1:0]     opcode;
  } mpwm_sts_t;

endpackage

/* hdl/mpwm_ctrl.sv */
// Controller for the PWM scheduler: sequences item capture, scaling wait, the opcode
// command or the channel walk of a service, and the result. Depends on mpwm_pkg.
module mpwm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  input  mpwm_pkg::mpwm_sts_t sts_i,
  output mpwm_pkg::mpwm_cmd_t cmd_o
);
  import mpwm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCALE = 5'b00010,
    S_EXEC  = 5'b00100,
    S_WALK  = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [ChW-1:0] ch_q, ch_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.svc_ch = ch_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCALE;
        end
      end
      // products are registered in the datapath during this cycle
      S_SCALE: state_d = S_EXEC;
      S_EXEC: begin
        case (opcode_e'(sts_i.opcode))
          OP_SERVICE: begin
            if (sts_i.any_enabled) begin
              cmd_o.svc_start = 1'b1;
              ch_d    = '0;
              state_d = S_WALK;
            end else begin
              state_d = S_FIN;
            end
          end
          OP_ENABLE:  begin cmd_o.do_enable  = 1'b1; state_d = S_FIN; end
          OP_DISABLE: begin cmd_o.do_disable = 1'b1; state_d = S_FIN; end
          OP_ADJUST:  begin cmd_o.do_adjust  = 1'b1; state_d = S_FIN; end
          default:    state_d = S_FIN;
        endcase
      end
      S_WALK: begin
        cmd_o.svc_step = 1'b1;
        ch_d = ch_q + 1'b1;
        if (ch_q == ChW'(Channels - 1)) begin
          cmd_o.svc_done = 1'b1;
          state_d = S_FIN;
        end
      end
      // wait here while the previous result is still held in the output register
      S_FIN: begin
        if (!(out_valid_q && out_stall_i)) begin
          cmd_o.set_result = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hdl/mpwm_datapath.sv */
// Datapath for the PWM scheduler: channel state, time stores, scaling
// multipliers, the per-channel service step and the result register. Depends on mpwm_pkg.
module mpwm_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           ticks_per_us_i,
  input  logic [15:0]          min_gap_ticks_i,
  input  logic [1:0]           opcode_i,
  input  logic [31:0]          now_i,
  input  logic [2:0]           channel_i,
  input  logic [23:0]          on_time_us_i,
  input  logic [23:0]          off_time_us_i,
  input  logic                 on_level_i,
  input  logic                 off_level_i,
  input  mpwm_pkg::mpwm_cmd_t  cmd_i,
  output mpwm_pkg::mpwm_sts_t  sts_o,
  output logic [7:0]           pin_levels_o,
  output logic [31:0]          compare_time_o,
  output logic                 timer_running_o,
  output logic                 accepted_o,
  output logic [2:0]           slot_o
);
  import mpwm_pkg::*;

  // captured item
  logic [1:0]  op_q;
  logic [31:0] now_q;
  logic [2:0]  chan_q;
  logic [23:0] on_us_q, off_us_q;
  logic        on_lv_q, off_lv_q;
  logic [31:0] on_ticks_q, off_ticks_q;

  logic [Channels-1:0] en_q, phase_q, sel_q, pend_q, pin_q;
  logic [31:0]         next_q [Channels];
  logic [31:0]         on_st_q  [2][Channels];
  logic [31:0]         off_st_q [2][Channels];
  logic [1:0]          lvl_q [Channels];
  logic [31:0]         cmp_q;
  logic [31:0]         nearest_q;

  logic [7:0]  res_pins_q;
  logic [31:0] res_cmp_q;
  logic        res_run_q, res_acc_q;
  logic [2:0]  res_slot_q;

  logic [ChW-1:0] free_idx_q;
  logic           enable_refused_q;

  // lowest free slot
  logic            free_found;
  logic [ChW-1:0]  free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = Channels - 1; i >= 0; i--) begin
      if (!en_q[i]) begin
        free_found = 1'b1;
        free_idx   = ChW'(i);
      end
    end
  end

  logic chan_ok;
  assign chan_ok = {29'd0, chan_q} < 32'(Channels);
  logic [ChW-1:0] ch_idx;
  assign ch_idx = chan_q[ChW-1:0];

  // service step for channel cmd_i.svc_ch
  logic [ChW-1:0] sc;
  logic [31:0]    delta0, delta1, len, delta_fin, nearest_d, target, floor_t, diff;
  logic           expired, ph_new, sel_new, pend_new;
  assign sc = cmd_i.svc_ch;
  always_comb begin
    delta0   = next_q[sc] - now_q;
    expired  = (delta0 == 32'd0) || delta0[31];
    ph_new   = ~phase_q[sc];
    sel_new  = sel_q[sc];
    pend_new = pend_q[sc];
    if (pend_q[sc] && !ph_new) begin
      sel_new  = ~sel_q[sc];
      pend_new = 1'b0;
    end
    len    = ph_new ? on_st_q[sel_new][sc] : off_st_q[sel_new][sc];
    delta1 = delta0 + len;
    if (delta1[31]) delta1 = len;
    delta_fin = expired ? delta1 : delta0;
    nearest_d = nearest_q;
    if (en_q[sc] && delta_fin < nearest_q) nearest_d = delta_fin;
    target  = now_q + nearest_d;
    floor_t = now_q + {16'd0, min_gap_ticks_i};
    diff    = target - floor_t;
    if ((diff == 32'd0) || diff[31]) target = floor_t;
  end

  // payload registers (no reset needed)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= opcode_i;
      now_q    <= now_i;
      chan_q   <= channel_i;
      on_us_q  <= on_time_us_i;
      off_us_q <= off_time_us_i;
      on_lv_q  <= on_level_i;
      off_lv_q <= off_level_i;
    end
    on_ticks_q  <= 32'({8'd0, on_us_q} * {24'd0, ticks_per_us_i});
    off_ticks_q <= 32'({8'd0, off_us_q} * {24'd0, ticks_per_us_i});
    if (cmd_i.svc_start) nearest_q <= NearestCap;
    if (cmd_i.svc_step)  nearest_q <= nearest_d;
    if (cmd_i.do_enable && free_found) begin
      on_st_q[0][free_idx]  <= on_ticks_q;
      off_st_q[0][free_idx] <= off_ticks_q;
      lvl_q[free_idx]       <= 2'b00;
      sel_q[free_idx]       <= 1'b0;
      pend_q[free_idx]      <= 1'b0;
      for (int i = 0; i < Channels; i++) begin
        if (en_q[i] || i == int'(free_idx)) begin
          phase_q[i] <= 1'b1;
          next_q[i]  <= now_q;
        end
      end
    end
    if (cmd_i.do_adjust && chan_ok) begin
      on_st_q[~sel_q[ch_idx]][ch_idx]  <= on_ticks_q;
      off_st_q[~sel_q[ch_idx]][ch_idx] <= off_ticks_q;
      lvl_q[ch_idx]  <= {on_lv_q, off_lv_q};
      pend_q[ch_idx] <= 1'b1;
    end
    if (cmd_i.svc_step && en_q[sc] && expired) begin
      phase_q[sc] <= ph_new;
      sel_q[sc]   <= sel_new;
      pend_q[sc]  <= pend_new;
      next_q[sc]  <= now_q + delta1;
    end
    if (cmd_i.set_result) begin
      res_pins_q <= pin_q[7:0];
      res_cmp_q  <= cmp_q;
      res_run_q  <= |en_q;
      res_acc_q  <= !(op_q == OP_ENABLE && enable_refused_q);
      res_slot_q <= (op_q == OP_ENABLE && !enable_refused_q) ? 3'(free_idx_q) : 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= '0;
      pin_q      <= '0;
      cmp_q      <= '0;
      free_idx_q <= '0;
    end else begin
      if (cmd_i.do_enable && free_found) begin
        en_q[free_idx]  <= 1'b1;
        pin_q[free_idx] <= 1'b0;
        cmp_q      <= now_q + {16'd0, min_gap_ticks_i};
        free_idx_q <= free_idx;
      end
      if (cmd_i.do_disable && chan_ok) en_q[ch_idx] <= 1'b0;
      if (cmd_i.svc_step && en_q[sc] && expired) pin_q[sc] <= lvl_q[sc][ph_new];
      if (cmd_i.svc_done) cmp_q <= target;
    end
  end

  // the enable outcome is kept, since the slot it took is no longer free
  // by the time the result is captured
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) enable_refused_q <= 1'b0;
    else if (cmd_i.do_enable) enable_refused_q <= !free_found;
  end

  assign sts_o.any_enabled = |en_q;
  assign sts_o.opcode      = op_q;
  assign pin_levels_o      = res_pins_q;
  assign compare_time_o    = res_cmp_q;
  assign timer_running_o   = res_run_q;
  assign accepted_o        = res_acc_q;
  assign slot_o            = res_slot_q;

endmodule

/* hdl/multichannel_pwm_scheduler.sv */
// Multichannel PWM scheduler, top level.
// From acceptance an item passes the scale and execute states to the final state that gives
// its result; a service with channels enabled first walks the channels, one per step.
// Items are taken one at a time, each after the last is done; a result still held by
// the receiver keeps the next item in its last state until it is taken.
// Reset: asynchronous active low; all channels disabled, pins low, compare 0,
// ticks_per_us 25, min_gap_ticks 250.
module multichannel_pwm_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] now_i,
  input  logic [2:0]  channel_i,
  input  logic [23:0] on_time_us_i,
  input  logic [23:0] off_time_us_i,
  input  logic        on_level_i,
  input  logic        off_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  pin_levels_o,
  output logic [31:0] compare_time_o,
  output logic        timer_running_o,
  output logic        accepted_o,
  output logic [2:0]  slot_o
);
  import mpwm_pkg::*;

  logic [7:0]  ticks_q;
  logic [15:0] gap_q;
  mpwm_cmd_t   cmd;
  mpwm_sts_t   sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= 8'd25;
      gap_q   <= 16'd250;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_TICKS_PER_US: ticks_q <= cfg_data_i[7:0];
        REG_MIN_GAP:      gap_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mpwm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_stall_i, .out_valid_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  mpwm_datapath u_dp (
    .clk_i, .rst_ni,
    .ticks_per_us_i(ticks_q), .min_gap_ticks_i(gap_q),
    .opcode_i, .now_i, .channel_i, .on_time_us_i, .off_time_us_i,
    .on_level_i, .off_level_i,
    .cmd_i(cmd), .sts_o(sts),
    .pin_levels_o, .compare_time_o, .timer_running_o, .accepted_o, .slot_o
  );

endmodule

/* sim/tb_multichannel_pwm_scheduler.sv */
// Testbench for multichannel_pwm_scheduler: random and directed PWM commands,
// checked against an in-bench scheduler model. Depends on mpwm_pkg and the block.
`timescale 1ns / 100ps

module tb_multichannel_pwm_scheduler;
  import mpwm_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int HoldCycles    = 400;
  localparam int PhaseItems    = 500;

  typedef struct {
    opcode_e     op;
    logic [31:0] now;
    logic [2:0]  ch;
    logic [23:0] on_us;
    logic [23:0] off_us;
    logic        on_lv;
    logic        off_lv;
  } pwm_cmd_t;

  typedef struct {
    logic [7:0]  pins;
    logic [31:0] cmp;
    logic        running;
    logic        acc;
    logic [2:0]  slot;
  } pwm_status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  reg_idx_e    cfg_index_i = REG_TICKS_PER_US;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [31:0] now_i = '0;
  logic [2:0]  channel_i = '0;
  logic [23:0] on_time_us_i = '0;
  logic [23:0] off_time_us_i = '0;
  logic        on_level_i = 1'b0;
  logic        off_level_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [7:0]  pin_levels_o;
  logic [31:0] compare_time_o;
  logic        timer_running_o;
  logic        accepted_o;
  logic [2:0]  slot_o;

  multichannel_pwm_scheduler DUT (.*);

  always #2 clk_i = ~clk_i;

  // model state
  bit [7:0]  tick_scale = 8'd25;
  bit [15:0] gap_ticks  = 16'd250;
  bit        ch_on [Channels];
  bit        ch_phase [Channels];
  bit [31:0] ch_next [Channels];
  bit        ch_sel [Channels];
  bit        ch_swap [Channels];
  bit [31:0] off_ticks [2*Channels];
  bit [31:0] on_ticks [2*Channels];
  bit [1:0]  ch_lvl [Channels];
  bit [7:0]  pin_reg;
  bit [31:0] cmp_reg;

  pwm_cmd_t    pending_cmds[$];
  pwm_status_t status_due[$];
  pwm_cmd_t    offered;
  bit          calm = 1'b0;
  bit          sender_pause = 1'b0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          errors = 0;
  int          quiet_cycles = 0;

  // stimulus-side tracking of which slots are enabled or were ever enabled
  bit        gen_on [Channels];
  bit        gen_seen [Channels];
  bit [31:0] gen_now;

  function automatic bit [31:0] to_ticks(bit [23:0] us);
    return {8'd0, us} * {24'd0, tick_scale};
  endfunction

  function automatic bit expired(bit [31:0] d);
    return d == 0 || d[31];
  endfunction

  function automatic pwm_status_t schedule_step(pwm_cmd_t c);
    pwm_status_t r;
    bit [31:0] nearest, delta, len, target, floor_t;
    bit        ph, any;
    int        found;
    r.acc = 1'b1;
    r.slot = '0;
    any = 1'b0;
    foreach (ch_on[i]) any |= ch_on[i];
    case (c.op)
      OP_SERVICE: if (any) begin
        nearest = NearestCap;
        for (int i = 0; i < Channels; i++) begin
          if (!ch_on[i]) continue;
          delta = ch_next[i] - c.now;
          if (expired(delta)) begin
            ph = ~ch_phase[i];
            ch_phase[i] = ph;
            pin_reg[i] = ch_lvl[i][ph];
            if (ch_swap[i] && !ph) begin
              ch_sel[i] ^= 1'b1;
              ch_swap[i] = 1'b0;
            end
            len = ph ? on_ticks[ch_sel[i]*Channels + i] : off_ticks[ch_sel[i]*Channels + i];
            delta += len;
            if (delta[31]) delta = len;
            ch_next[i] = c.now + delta;
          end
          if (delta < nearest) nearest = delta;
        end
        target = c.now + nearest;
        floor_t = c.now + gap_ticks;
        if (expired(target - floor_t)) target = floor_t;
        cmp_reg = target;
      end
      OP_ENABLE: begin
        found = -1;
        for (int i = 0; i < Channels; i++)
          if (!ch_on[i] && found < 0) found = i;
        if (found < 0) begin
          r.acc = 1'b0;
        end else begin
          off_ticks[found] = to_ticks(c.off_us);
          on_ticks[found] = to_ticks(c.on_us);
          ch_lvl[found] = '0;
          ch_sel[found] = 1'b0;
          ch_swap[found] = 1'b0;
          pin_reg[found] = 1'b0;
          ch_on[found] = 1'b1;
          for (int i = 0; i < Channels; i++)
            if (ch_on[i]) begin
              ch_phase[i] = 1'b1;
              ch_next[i] = c.now;
            end
          cmp_reg = c.now + gap_ticks;
          r.slot = found[2:0];
        end
      end
      OP_DISABLE: ch_on[c.ch] = 1'b0;
      default: begin
        off_ticks[(ch_sel[c.ch] ^ 1'b1)*Channels + c.ch] = to_ticks(c.off_us);
        on_ticks[(ch_sel[c.ch] ^ 1'b1)*Channels + c.ch] = to_ticks(c.on_us);
        ch_lvl[c.ch] = {c.on_lv, c.off_lv};
        ch_swap[c.ch] = 1'b1;
      end
    endcase
    any = 1'b0;
    foreach (ch_on[i]) any |= ch_on[i];
    r.pins = pin_reg;
    r.cmp = cmp_reg;
    r.running = any;
    return r;
  endfunction

  task automatic queue_cmd(opcode_e op, bit [31:0] now, bit [2:0] ch,
                           bit [23:0] on_us, bit [23:0] off_us, bit on_lv, bit off_lv);
    pwm_cmd_t c;
    int       slot;
    c = '{op, now, ch, on_us, off_us, on_lv, off_lv};
    if (op == OP_ENABLE) begin
      slot = -1;
      for (int i = 0; i < Channels; i++)
        if (!gen_on[i] && slot < 0) slot = i;
      if (slot >= 0) begin
        gen_on[slot] = 1'b1;
        gen_seen[slot] = 1'b1;
      end
    end else if (op == OP_DISABLE) begin
      gen_on[ch] = 1'b0;
    end
    pending_cmds.push_back(c);
  endtask

  // adjust only targets slots that have been enabled at some point
  function automatic int seen_slot();
    int picks[$];
    for (int i = 0; i < Channels; i++) if (gen_seen[i]) picks.push_back(i);
    if (picks.size() == 0) return -1;
    return picks[$urandom_range(0, picks.size() - 1)];
  endfunction

  task automatic random_cmd();
    int          sel, ch;
    bit [23:0]   on_us, off_us;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) begin
      on_us = 24'($urandom);
      off_us = 24'($urandom);
    end else begin
      on_us = 24'($urandom_range(0, 40));
      off_us = 24'($urandom_range(0, 40));
    end
    if ($urandom_range(0, 19) == 0) gen_now = $urandom;
    else gen_now += $urandom_range(0, 1500);
    ch = seen_slot();
    if (sel < 55 || (sel >= 85 && ch < 0))
      queue_cmd(OP_SERVICE, gen_now, 3'($urandom), on_us, off_us, 1'($urandom), 1'($urandom));
    else if (sel < 72)
      queue_cmd(OP_ENABLE, gen_now, 3'($urandom), on_us, off_us, 1'($urandom), 1'($urandom));
    else if (sel < 85)
      queue_cmd(OP_DISABLE, gen_now, 3'($urandom), on_us, off_us, 1'($urandom), 1'($urandom));
    else
      queue_cmd(OP_ADJUST, gen_now, 3'(ch), on_us, off_us, 1'($urandom), 1'($urandom));
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid_i || status_due.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, bit [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_TICKS_PER_US) tick_scale = val[7:0];
    else gap_ticks = val;
  endtask

  task automatic directed_cmds();
    queue_cmd(OP_SERVICE, 32'd100, 3'd0, '0, '0, 1'b0, 1'b0);      // nothing enabled
    queue_cmd(OP_ENABLE, 32'd0, 3'd0, 24'd0, 24'd0, 1'b0, 1'b0);   // zero-length phases
    queue_cmd(OP_SERVICE, 32'd0, 3'd0, '0, '0, 1'b0, 1'b0);
    queue_cmd(OP_ENABLE, 32'hffff_fff0, 3'd0, 24'hff_ffff, 24'hff_ffff, 1'b1, 1'b1);
    queue_cmd(OP_ADJUST, 32'hffff_fff0, 3'd0, 24'd4, 24'd6, 1'b1, 1'b0);
    queue_cmd(OP_ADJUST, 32'hffff_fff0, 3'd1, 24'd3, 24'd5, 1'b0, 1'b1);
    queue_cmd(OP_SERVICE, 32'hffff_ffff, 3'd0, '0, '0, 1'b0, 1'b0); // counter wrap
    queue_cmd(OP_SERVICE, 32'h0000_0080, 3'd0, '0, '0, 1'b0, 1'b0);
    for (int i = 0; i < 7; i++)                                      // ninth one is refused
      queue_cmd(OP_ENABLE, 32'h200, 3'd0, 24'(i + 1), 24'(2 * i + 1), 1'b0, 1'b0);
    queue_cmd(OP_ADJUST, 32'h200, 3'd7, 24'd2, 24'd2, 1'b1, 1'b1);
    queue_cmd(OP_SERVICE, 32'h200, 3'd0, '0, '0, 1'b0, 1'b0);
    queue_cmd(OP_SERVICE, 32'h7fff_0000, 3'd0, '0, '0, 1'b0, 1'b0); // far past every event
    queue_cmd(OP_DISABLE, 32'h0, 3'd7, '0, '0, 1'b0, 1'b0);
    queue_cmd(OP_ADJUST, 32'h0, 3'd7, 24'd9, 24'd9, 1'b0, 1'b1);   // disabled channel
    for (int i = 0; i < 7; i++)
      queue_cmd(OP_DISABLE, 32'h0, 3'(i), '0, '0, 1'b0, 1'b0);
    queue_cmd(OP_SERVICE, 32'h300, 3'd0, '0, '0, 1'b0, 1'b0);
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        status_due.push_back(schedule_step(offered));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_cmds.size() == 0 || sender_pause || (!calm && $urandom_range(0, 99) < 37)) begin
          in_valid_i <= 1'b0;
        end else begin
          offered = pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          opcode_i <= offered.op;
          now_i <= offered.now;
          channel_i <= offered.ch;
          on_time_us_i <= offered.on_us;
          off_time_us_i <= offered.off_us;
          on_level_i <= offered.on_lv;
          off_level_i <= offered.off_lv;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // output monitor
  always @(posedge clk_i) begin
    pwm_status_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (status_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, actual pins %h compare %h", $time,
                   pin_levels_o, compare_time_o);
        end else begin
          want = status_due.pop_front();
          check_field("pin_levels", want.pins, pin_levels_o);
          check_field("compare_time", want.cmp, compare_time_o);
          check_field("timer_running", want.running, timer_running_o);
          check_field("accepted", want.acc, accepted_o);
          check_field("slot", want.slot, slot_o);
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HoldCycles;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && $urandom_range(0, 99) < 37;
      end
    end
  end

  // watchdog: counts cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    gen_now = 32'd1000;
    @(posedge clk_i);
    for (int p = 0; p < 4; p++) begin
      case (p)
        1: begin
          write_reg(REG_TICKS_PER_US, 16'd1);
          write_reg(REG_MIN_GAP, 16'd0);
        end
        2: begin
          write_reg(REG_TICKS_PER_US, 16'd255);
          write_reg(REG_MIN_GAP, 16'hffff);
        end
        3: begin
          write_reg(REG_TICKS_PER_US, 16'($urandom_range(1, 255)));
          write_reg(REG_MIN_GAP, 16'($urandom));
        end
        default: ;
      endcase
      calm = (p == 1);
      if (p == 2) hold_req++;   // long receiver hold-off while the sender keeps offering
      directed_cmds();
      for (int n = 0; n < PhaseItems; n++) random_cmd();
      if (p == 3) begin
        while (pending_cmds.size() > PhaseItems / 2) @(posedge clk_i);
        sender_pause = 1'b1;
        while (in_valid_i || status_due.size() != 0) @(posedge clk_i);
        sender_pause = 1'b0;
      end
      wait_idle();
      calm = 1'b0;
    end
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
